### hdl/sps_pkg.sv
// Shared types and constants for the segment point sampler.
package sps_pkg;

  localparam int unsigned CoordW     = 31;
  localparam int unsigned SpacingW   = 30;
  localparam int unsigned MaxPointsD = 64;

  typedef enum logic {
    OP_SQRT,
    OP_DIV
  } sps_op_e;

  typedef struct packed {
    logic    start;
    sps_op_e op;
  } sps_cmd_t;

endpackage

### hdl/sps_if.sv
// Valid/ready channel interfaces for segment items and sampled point items.
interface sps_seg_if import sps_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [CoordW-1:0]   robot_x;
  logic signed [CoordW-1:0]   robot_y;
  logic signed [CoordW-1:0]   obstacle_x;
  logic signed [CoordW-1:0]   obstacle_y;
  logic        [SpacingW-1:0] spacing;

  modport source (output valid, robot_x, robot_y, obstacle_x, obstacle_y, spacing,
                  input ready);
  modport sink   (input valid, robot_x, robot_y, obstacle_x, obstacle_y, spacing,
                  output ready);
endinterface

interface sps_pt_if import sps_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] point_x;
  logic signed [CoordW-1:0] point_y;
  logic                     last_point;
  logic                     truncated;

  modport source (output valid, point_x, point_y, last_point, truncated, input ready);
  modport sink   (input valid, point_x, point_y, last_point, truncated, output ready);
endinterface

### hdl/sps_iter.sv
// Shared shift-and-subtract unit: bitwise square root or restoring division.
module sps_iter import sps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sps_cmd_t    cmd_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [63:0] res_o
);

  logic        busy_q, done_q;
  sps_op_e     op_q;
  logic [5:0]  cnt_q;
  logic [63:0] acc_q, res_q;
  logic [33:0] rem_q;
  logic [31:0] den_q;

  logic [33:0] rem_sh, trial, rem_next;
  logic [34:0] diff;
  logic        ge;

  always_comb begin
    if (op_q == OP_SQRT) begin
      rem_sh = {rem_q[31:0], acc_q[63:62]};
      trial  = {res_q[31:0], 2'b01};
    end else begin
      rem_sh = {rem_q[32:0], acc_q[63]};
      trial  = {2'b00, den_q};
    end
    diff     = {1'b0, rem_sh} - {1'b0, trial};
    ge       = ~diff[34];
    rem_next = ge ? diff[33:0] : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_SQRT;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        op_q   <= cmd_i.op;
        cnt_q  <= (cmd_i.op == OP_SQRT) ? 6'd31 : 6'd63;
      end else if (busy_q) begin
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      acc_q <= num_i;
      rem_q <= '0;
      res_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      acc_q <= (op_q == OP_SQRT) ? {acc_q[61:0], 2'b00} : {acc_q[62:0], 1'b0};
      rem_q <= rem_next;
      res_q <= {res_q[62:0], ge};
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### hdl/segment_point_sampler.sv
// Top level: segment setup sequencer, shared multiplier and point stepping.
//
//   Channel | Dir | Payload                                           | Accepted when
//   seg_i   | in  | robot_x, robot_y, obstacle_x, obstacle_y, spacing | valid & ready
//   pt_o    | out | point_x, point_y, last_point, truncated          | valid & ready
//
// After a segment is accepted, setup squares dx and dy in S_CHK and S_SQY, then runs
// the 32-step square root and each 64-step division on one shared shift-and-subtract
// unit (start, one step per cycle, done); the spacing products are formed on the
// shared multiplier in the done cycles. A counting pass then walks the points (up to
// MAX_POINTS when cut), and an emit pass delivers one point per cycle while pt_o is
// ready.
// seg_i is ready only when idle; a last point may still wait in the output register.
// Reset clears the sequencer and the output valid.
module segment_point_sampler import sps_pkg::*; #(
  parameter int unsigned MAX_POINTS = MaxPointsD
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sps_seg_if.sink   seg_i,
  sps_pt_if.source  pt_o
);

  localparam int unsigned CntW = $clog2(MAX_POINTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_SQY, S_SQRT, S_SQRTW, S_DIVX, S_DIVXW, S_DIVY, S_DIVYW,
    S_COUNT, S_EMIT
  } state_e;

  state_e state_q;

  logic signed [CoordW-1:0]   x0_q, y0_q, x2_q, y2_q, xc_q, yc_q;
  logic        [SpacingW-1:0] sp_q;
  logic        [CoordW-1:0]   dx_q;
  logic        [31:0]         len_q;
  logic        [SpacingW-1:0] sx_q, sy_q;
  logic        [63:0]         prod_q, sum_q;
  logic                       up_q, trunc_q;
  logic        [CntW-1:0]     n_q, emit_q;

  logic                       ov_q, last_q, otrunc_q;
  logic signed [CoordW-1:0]   px_q, py_q;

  // Setup arithmetic.
  logic signed [CoordW:0] dx_w, dy_w;
  logic        [CoordW-1:0] dy_abs;
  logic        [31:0] mul_a, mul_b;
  logic        [63:0] prod_d;

  always_comb begin
    dx_w   = {x2_q[CoordW-1], x2_q} - {x0_q[CoordW-1], x0_q};
    dy_w   = {y2_q[CoordW-1], y2_q} - {y0_q[CoordW-1], y0_q};
    dy_abs = dy_w[CoordW] ? CoordW'(-dy_w) : dy_w[CoordW-1:0];
    unique case (state_q)
      S_CHK:   begin mul_a = 32'(dx_w[CoordW-1:0]); mul_b = 32'(dx_w[CoordW-1:0]); end
      S_SQY:   begin mul_a = 32'(dy_abs);           mul_b = 32'(dy_abs);           end
      S_SQRTW: begin mul_a = 32'(sp_q);             mul_b = 32'(dx_q);             end
      default: begin mul_a = 32'(sp_q);             mul_b = 32'(dy_abs);           end
    endcase
    prod_d = 64'(mul_a) * 64'(mul_b);
  end

  // Shared iterative unit.
  sps_cmd_t    cmd;
  logic [63:0] num, it_res;
  logic        it_done;

  always_comb begin
    cmd.start = (state_q == S_SQRT) || (state_q == S_DIVX) || (state_q == S_DIVY);
    cmd.op    = (state_q == S_SQRT) ? OP_SQRT : OP_DIV;
    num       = (state_q == S_SQRT) ? (sum_q + prod_q) : prod_q;
  end

  sps_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .num_i  (num),
    .den_i  (len_q),
    .done_o (it_done),
    .res_o  (it_res)
  );

  // Next point from the current one.
  logic signed [CoordW+1:0] nx, ny;
  logic                     fits;

  always_comb begin
    nx = {{2{xc_q[CoordW-1]}}, xc_q} + {3'b000, sx_q};
    if (up_q) ny = {{2{yc_q[CoordW-1]}}, yc_q} + {3'b000, sy_q};
    else      ny = {{2{yc_q[CoordW-1]}}, yc_q} - {3'b000, sy_q};
    fits = (nx <= $signed({{2{x2_q[CoordW-1]}}, x2_q})) &&
           (up_q ? (ny <= $signed({{2{y2_q[CoordW-1]}}, y2_q}))
                 : (ny >= $signed({{2{y2_q[CoordW-1]}}, y2_q})));
  end

  logic swap;
  assign swap = seg_i.robot_x > seg_i.obstacle_x;
  logic slot_free;
  assign slot_free = !ov_q || pt_o.ready;
  logic load_pt;
  assign load_pt = (state_q == S_EMIT) && slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      if (load_pt)          ov_q <= 1'b1;
      else if (pt_o.ready)  ov_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (seg_i.valid) begin
            x0_q    <= swap ? seg_i.obstacle_x : seg_i.robot_x;
            y0_q    <= swap ? seg_i.obstacle_y : seg_i.robot_y;
            x2_q    <= swap ? seg_i.robot_x : seg_i.obstacle_x;
            y2_q    <= swap ? seg_i.robot_y : seg_i.obstacle_y;
            sp_q    <= seg_i.spacing;
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          dx_q   <= dx_w[CoordW-1:0];
          up_q   <= !dy_w[CoordW];
          prod_q <= prod_d;
          if (sp_q == '0 || (dx_w == '0 && dy_w == '0)) state_q <= S_IDLE;
          else                                          state_q <= S_SQY;
        end
        S_SQY: begin
          sum_q   <= prod_q;
          prod_q  <= prod_d;
          state_q <= S_SQRT;
        end
        S_SQRT: state_q <= S_SQRTW;
        S_SQRTW: begin
          if (it_done) begin
            len_q   <= it_res[31:0];
            prod_q  <= prod_d;
            state_q <= S_DIVX;
          end
        end
        S_DIVX: state_q <= S_DIVXW;
        S_DIVXW: begin
          if (it_done) begin
            sx_q    <= it_res[SpacingW-1:0];
            prod_q  <= prod_d;
            state_q <= S_DIVY;
          end
        end
        S_DIVY: state_q <= S_DIVYW;
        S_DIVYW: begin
          if (it_done) begin
            sy_q    <= it_res[SpacingW-1:0];
            xc_q    <= x0_q;
            yc_q    <= y0_q;
            n_q     <= '0;
            trunc_q <= 1'b0;
            state_q <= S_COUNT;
          end
        end
        S_COUNT: begin
          // Counting pass: the truncated flag must be known before the first item leaves.
          emit_q <= '0;
          if (!fits) begin
            xc_q    <= x0_q;
            yc_q    <= y0_q;
            state_q <= (n_q == '0) ? S_IDLE : S_EMIT;
          end else if (n_q == CntW'(MAX_POINTS)) begin
            xc_q    <= x0_q;
            yc_q    <= y0_q;
            trunc_q <= 1'b1;
            state_q <= S_EMIT;
          end else begin
            n_q  <= n_q + CntW'(1);
            xc_q <= nx[CoordW-1:0];
            yc_q <= ny[CoordW-1:0];
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            px_q     <= nx[CoordW-1:0];
            py_q     <= ny[CoordW-1:0];
            otrunc_q <= trunc_q;
            last_q   <= (emit_q + CntW'(1)) == n_q;
            xc_q     <= nx[CoordW-1:0];
            yc_q     <= ny[CoordW-1:0];
            emit_q   <= emit_q + CntW'(1);
            if ((emit_q + CntW'(1)) == n_q) state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign seg_i.ready     = (state_q == S_IDLE);
  assign pt_o.valid      = ov_q;
  assign pt_o.point_x    = px_q;
  assign pt_o.point_y    = py_q;
  assign pt_o.last_point = last_q;
  assign pt_o.truncated  = otrunc_q;

endmodule
